[rtl/generation_handle_allocator_core_assert.svh]
// assertion macros shared by the allocator rtl
`ifndef GENERATION_HANDLE_ALLOCATOR_CORE_ASSERT_SVH
`define GENERATION_HANDLE_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock outside reset
`define GHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gha assertion failed");
// condition must never be seen outside reset
`define GHA_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gha forbidden condition seen");
`else
`define GHA_ASSERT(lbl, clk, rst_n, prop)
`define GHA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/gha_pkg.sv]
package gha_pkg;

    // operation codes on the input word
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    // status codes on the result word
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_HANDLE  = 2'd1;
    localparam logic [1:0] STATUS_NO_FREE     = 2'd2;
    localparam logic [1:0] STATUS_DOUBLE_FREE = 2'd3;

    // decoded command flags passed from front to back
    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic is_lookup;
        logic handle_zero;
        logic check_perm;
    } cmd_ctrl_t;

    // back end sequencer
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } back_state_t;

endpackage

[rtl/gha_ram.sv]
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/gha_front.sv]
`include "generation_handle_allocator_core_assert.svh"

module gha_front #(
    parameter int HANDLE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_func,
    input  logic [HANDLE_BITS-1:0] s_handle,
    input  logic [HANDLE_BITS-1:0] s_parent_handle,
    input  logic                   s_check_perm,
    input  logic [HANDLE_BITS-1:0] s_current_handle,
    output logic                   q_valid,
    input  logic                   q_ready,
    output gha_pkg::cmd_ctrl_t     q_ctrl,
    output logic [HANDLE_BITS-1:0] q_handle,
    output logic [HANDLE_BITS-1:0] q_parent,
    output logic [HANDLE_BITS-1:0] q_current
);

    gha_pkg::cmd_ctrl_t     ctrl_mem_reg    [2];
    logic [HANDLE_BITS-1:0] handle_mem_reg  [2];
    logic [HANDLE_BITS-1:0] parent_mem_reg  [2];
    logic [HANDLE_BITS-1:0] current_mem_reg [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    gha_pkg::cmd_ctrl_t in_ctrl;
    logic               push;
    logic               pop;

    // classify the incoming word
    always_comb begin
        in_ctrl.is_alloc    = (s_func == gha_pkg::FUNC_ALLOC);
        in_ctrl.is_free     = (s_func == gha_pkg::FUNC_FREE);
        in_ctrl.is_lookup   = (s_func == gha_pkg::FUNC_LOOKUP);
        in_ctrl.handle_zero = (s_handle == '0);
        in_ctrl.check_perm  = s_check_perm;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;

    // two-entry command queue
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge aclk) begin
        if (push) begin
            ctrl_mem_reg[wr_ptr_reg]    <= in_ctrl;
            handle_mem_reg[wr_ptr_reg]  <= s_handle;
            parent_mem_reg[wr_ptr_reg]  <= s_parent_handle;
            current_mem_reg[wr_ptr_reg] <= s_current_handle;
        end
    end

    assign q_ctrl    = ctrl_mem_reg[rd_ptr_reg];
    assign q_handle  = handle_mem_reg[rd_ptr_reg];
    assign q_parent  = parent_mem_reg[rd_ptr_reg];
    assign q_current = current_mem_reg[rd_ptr_reg];

    `GHA_NEVER(a_queue_overfill, aclk, aresetn, count_reg == 2'd3)
    `GHA_ASSERT(a_queue_ptr_gap, aclk, aresetn, (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
    `GHA_ASSERT(a_queue_full_block, aclk, aresetn, (count_reg == 2'd2 && !q_ready) |=> (count_reg == 2'd2))

endmodule

[rtl/gha_back.sv]
`include "generation_handle_allocator_core_assert.svh"

module gha_back #(
    parameter int INDEX_BITS  = 10,
    parameter int HANDLE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  gha_pkg::cmd_ctrl_t     q_ctrl,
    input  logic [HANDLE_BITS-1:0] q_handle,
    input  logic [HANDLE_BITS-1:0] q_parent,
    input  logic [HANDLE_BITS-1:0] q_current,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic [HANDLE_BITS-1:0] m_result_handle,
    output logic [INDEX_BITS-1:0]  m_slot_index
);

    localparam int SLOTS        = 1 << INDEX_BITS;
    localparam int SLOT_W       = 1 + 2 * HANDLE_BITS;
    localparam int GEN_BITS_RAW = HANDLE_BITS - INDEX_BITS - 1;
    localparam int GEN_W        = (GEN_BITS_RAW > 0) ? GEN_BITS_RAW : 1;
    localparam bit GEN_USED     = (GEN_BITS_RAW > 0);
    localparam logic [INDEX_BITS:0] SLOT_COUNT = {1'b1, {INDEX_BITS{1'b0}}};

    gha_pkg::back_state_t state_reg, state_next;

    // operation under execution
    gha_pkg::cmd_ctrl_t     op_ctrl_reg;
    logic [HANDLE_BITS-1:0] op_handle_reg;
    logic [HANDLE_BITS-1:0] op_parent_reg;
    logic [HANDLE_BITS-1:0] op_current_reg;

    logic [INDEX_BITS:0] freed_count_reg, freed_count_next;
    logic [INDEX_BITS:0] fresh_next_reg, fresh_next_next;
    logic [GEN_W-1:0]    gen_reg, gen_next;

    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_status_reg, m_status_next;
    logic [HANDLE_BITS-1:0] m_handle_reg, m_handle_next;
    logic [INDEX_BITS-1:0]  m_slot_reg, m_slot_next;

    logic pop;
    logic out_free;
    logic exec_done;

    // slot memory: {in_use, parent, handle}
    logic                  slot_we;
    logic [INDEX_BITS-1:0] slot_waddr;
    logic [SLOT_W-1:0]     slot_wdata;
    logic [SLOT_W-1:0]     slot_rdata;

    // freed index stack
    logic                  stack_we;
    logic [INDEX_BITS-1:0] stack_waddr;
    logic [INDEX_BITS-1:0] stack_wdata;
    logic [INDEX_BITS-1:0] stack_rdata;
    logic [INDEX_BITS:0]   freed_dec;

    logic                   rd_in_use;
    logic [HANDLE_BITS-1:0] rd_parent;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [INDEX_BITS-1:0]  idx;
    logic                   live;
    logic                   use_freed;
    logic                   table_full;
    logic [INDEX_BITS-1:0]  alloc_slot;
    logic [GEN_W-1:0]       gen_inc;
    logic [HANDLE_BITS-1:0] new_handle;
    logic                   perm_ok;

    assign q_ready   = (state_reg == gha_pkg::ST_IDLE);
    assign pop       = q_valid && q_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_done = (state_reg == gha_pkg::ST_EXEC) && out_free;
    assign freed_dec = freed_count_reg - 1'b1;

    gha_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk  (aclk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .re   (pop),
        .raddr(q_handle[INDEX_BITS-1:0]),
        .rdata(slot_rdata)
    );

    gha_ram #(
        .WIDTH(INDEX_BITS),
        .DEPTH(SLOTS)
    ) u_stack_ram (
        .clk  (aclk),
        .we   (stack_we),
        .waddr(stack_waddr),
        .wdata(stack_wdata),
        .re   (pop),
        .raddr(freed_dec[INDEX_BITS-1:0]),
        .rdata(stack_rdata)
    );

    // fields of the slot read when the operation was taken from the queue
    assign rd_in_use = slot_rdata[SLOT_W-1];
    assign rd_parent = slot_rdata[2*HANDLE_BITS-1:HANDLE_BITS];
    assign rd_handle = slot_rdata[HANDLE_BITS-1:0];
    assign idx       = op_handle_reg[INDEX_BITS-1:0];

    // slots at or above the fresh pointer were never written and read as unused
    assign live = ({1'b0, idx} < fresh_next_reg) && rd_in_use;

    // allocation choice and new handle
    assign use_freed  = (freed_count_reg != '0);
    assign table_full = !use_freed && (fresh_next_reg == SLOT_COUNT);
    assign alloc_slot = use_freed ? stack_rdata : fresh_next_reg[INDEX_BITS-1:0];
    assign gen_inc    = GEN_USED ? (gen_reg + 1'b1) : '0;
    assign new_handle = (HANDLE_BITS'(gen_inc) << (INDEX_BITS + 1))
                      | HANDLE_BITS'(alloc_slot);
    assign perm_ok    = (op_current_reg != '0)
                     && ((op_handle_reg == op_current_reg) || (rd_parent == op_current_reg));

    // execute the operation held in the back end
    always_comb begin
        freed_count_next = freed_count_reg;
        fresh_next_next  = fresh_next_reg;
        gen_next         = gen_reg;
        slot_we          = 1'b0;
        slot_waddr       = idx;
        slot_wdata       = {1'b0, rd_parent, rd_handle};
        stack_we         = 1'b0;
        stack_waddr      = freed_count_reg[INDEX_BITS-1:0];
        stack_wdata      = idx;
        m_status_next    = gha_pkg::STATUS_BAD_HANDLE;
        m_handle_next    = '0;
        m_slot_next      = '0;

        if (op_ctrl_reg.is_alloc) begin
            if (table_full) begin
                m_status_next = gha_pkg::STATUS_NO_FREE;
            end else begin
                m_status_next = gha_pkg::STATUS_OK;
                m_handle_next = new_handle;
                m_slot_next   = alloc_slot;
                gen_next      = gen_inc;
                slot_we       = 1'b1;
                slot_waddr    = alloc_slot;
                slot_wdata    = {1'b1, op_parent_reg, new_handle};
                if (use_freed) begin
                    freed_count_next = freed_dec;
                end else begin
                    fresh_next_next = fresh_next_reg + 1'b1;
                end
            end
        end else if (op_ctrl_reg.is_free) begin
            m_slot_next = idx;
            if (!live) begin
                m_status_next = gha_pkg::STATUS_DOUBLE_FREE;
            end else begin
                m_status_next = gha_pkg::STATUS_OK;
                slot_we       = 1'b1;
                if (freed_count_reg < SLOT_COUNT) begin
                    stack_we         = 1'b1;
                    freed_count_next = freed_count_reg + 1'b1;
                end
            end
        end else if (op_ctrl_reg.is_lookup) begin
            if (op_ctrl_reg.handle_zero) begin
                m_status_next = gha_pkg::STATUS_OK;
                m_handle_next = op_current_reg;
                m_slot_next   = op_current_reg[INDEX_BITS-1:0];
            end else begin
                m_slot_next = idx;
                if (live && (rd_handle == op_handle_reg)
                    && (!op_ctrl_reg.check_perm || perm_ok)) begin
                    m_status_next = gha_pkg::STATUS_OK;
                    m_handle_next = op_handle_reg;
                end
            end
        end

        // nothing commits until the result register can take the word
        if (!exec_done) begin
            slot_we          = 1'b0;
            stack_we         = 1'b0;
            freed_count_next = freed_count_reg;
            fresh_next_next  = fresh_next_reg;
            gen_next         = gen_reg;
        end
    end

    // sequencer and output valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            gha_pkg::ST_IDLE: begin
                if (pop) begin
                    state_next = gha_pkg::ST_EXEC;
                end
            end
            gha_pkg::ST_EXEC: begin
                if (exec_done) begin
                    state_next   = gha_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = gha_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= gha_pkg::ST_IDLE;
            freed_count_reg <= '0;
            fresh_next_reg  <= '0;
            gen_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            freed_count_reg <= freed_count_next;
            fresh_next_reg  <= fresh_next_next;
            gen_reg         <= gen_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            op_ctrl_reg    <= q_ctrl;
            op_handle_reg  <= q_handle;
            op_parent_reg  <= q_parent;
            op_current_reg <= q_current;
        end
        if (exec_done) begin
            m_status_reg <= m_status_next;
            m_handle_reg <= m_handle_next;
            m_slot_reg   <= m_slot_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_handle = m_handle_reg;
    assign m_slot_index    = m_slot_reg;

    `GHA_ASSERT(a_freed_within_used, aclk, aresetn, freed_count_reg <= fresh_next_reg)
    `GHA_ASSERT(a_fresh_bound, aclk, aresetn, fresh_next_reg <= SLOT_COUNT)
    `GHA_ASSERT(a_exec_completes, aclk, aresetn, exec_done |=> (state_reg == gha_pkg::ST_IDLE && m_valid_reg))
    `GHA_NEVER(a_write_outside_exec, aclk, aresetn, (slot_we || stack_we) && !exec_done)

endmodule

[rtl/generation_handle_allocator_core.sv]
// Generation-tagged handle allocator.
// Input channel (s_*): one word per operation: func selects allocate, free or
// lookup; handle, parent_handle, check_perm and current_handle are its operands.
// Result channel (m_*): exactly one word per operation, in order: status,
// result_handle and slot_index.
// An allocate reuses the most recently freed slot, else the lowest unused one,
// and returns handle = generation above bit INDEX_BITS, OR the slot index.
// An operation passes from the command queue through the slot memory read
// and the execute step into the result register.
// The back end takes no new operation until the current one is in the result
// register, as it reads then writes the slot memory for each. A two-word
// command queue lets the sender run ahead while the back end works.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result
// and marks every slot unused; no clearing pass is needed, slots at or above
// the fresh pointer always read as unused.
// When m_ready is low the result is held, the back end waits with its
// operation and the queue fills; s_ready falls once the queue holds two words.
module generation_handle_allocator_core #(
    parameter int INDEX_BITS  = 10,
    parameter int HANDLE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_func,
    input  logic [HANDLE_BITS-1:0] s_handle,
    input  logic [HANDLE_BITS-1:0] s_parent_handle,
    input  logic                   s_check_perm,
    input  logic [HANDLE_BITS-1:0] s_current_handle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic [HANDLE_BITS-1:0] m_result_handle,
    output logic [INDEX_BITS-1:0]  m_slot_index
);

    logic                   q_valid;
    logic                   q_ready;
    gha_pkg::cmd_ctrl_t     q_ctrl;
    logic [HANDLE_BITS-1:0] q_handle;
    logic [HANDLE_BITS-1:0] q_parent;
    logic [HANDLE_BITS-1:0] q_current;

    // decode and queue
    gha_front #(
        .HANDLE_BITS(HANDLE_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_handle        (s_handle),
        .s_parent_handle (s_parent_handle),
        .s_check_perm    (s_check_perm),
        .s_current_handle(s_current_handle),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_ctrl          (q_ctrl),
        .q_handle        (q_handle),
        .q_parent        (q_parent),
        .q_current       (q_current)
    );

    // table access and result
    gha_back #(
        .INDEX_BITS (INDEX_BITS),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_ctrl         (q_ctrl),
        .q_handle       (q_handle),
        .q_parent       (q_parent),
        .q_current      (q_current),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_handle(m_result_handle),
        .m_slot_index   (m_slot_index)
    );

endmodule
